@@ src/lrt_pkg.sv @@
package lrt_pkg;

  // Level geometry.
  localparam int MAX_RUNS        = 8;
  localparam int MAX_RUN_ENTRIES = 1024;
  localparam int KEY_BITS        = 32;

  localparam int RUN_W   = $clog2(MAX_RUNS);             // run number
  localparam int RCNT_W  = $clog2(MAX_RUNS + 1);         // run count, may equal MAX_RUNS
  localparam int POS_W   = $clog2(MAX_RUN_ENTRIES);      // position inside a run
  localparam int FILL_W  = $clog2(MAX_RUN_ENTRIES + 1);  // fill count of one run
  localparam int ADDR_W  = RUN_W + POS_W;
  localparam int CNT_W   = 14;                           // entry_count field
  localparam int BLK_W   = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int SF_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TIERING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_PER_RUN = 2'd2;

  localparam logic [SF_W-1:0]       SF_MIN   = 4'd2;
  localparam logic [SF_W-1:0]       SF_MAX   = 4'd8;
  localparam logic [SF_W-1:0]       SF_RESET = 4'd8;
  localparam logic [CFG_DATA_W-1:0] EPR_RESET = 11'd1024;

  // Leveling full limit for the reset configuration.
  localparam int LIM_RESET_INT = (int'(EPR_RESET) / int'(SF_RESET)) * (int'(SF_RESET) - 1);
  localparam logic [FILL_W-1:0] LIM_RESET = FILL_W'(LIM_RESET_INT);

  // Actions.
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_LOOKUP  = 2'd1;
  localparam logic [1:0] ACT_OVERLAP = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_REJECTED   = 3'd1;
  localparam logic [2:0] ST_HIT        = 3'd2;
  localparam logic [2:0] ST_MISS       = 3'd3;
  localparam logic [2:0] ST_OVERLAPS   = 3'd4;
  localparam logic [2:0] ST_NO_OVERLAP = 3'd5;
  localparam logic [2:0] ST_CLEARED    = 3'd6;

  typedef struct packed {
    logic [1:0]          action;
    logic [KEY_BITS-1:0] key_low;
    logic [KEY_BITS-1:0] key_high;
    logic [BLK_W-1:0]    block_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [2:0]          run_index;
    logic [KEY_BITS-1:0] found_key_low;
    logic [KEY_BITS-1:0] found_key_high;
    logic [BLK_W-1:0]    found_block;
    logic                level_full;
    logic [CNT_W-1:0]    entry_count;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_low;
    logic [KEY_BITS-1:0] key_high;
    logic [BLK_W-1:0]    block;
  } entry_t;

  function automatic logic [SF_W-1:0] eff_factor(input logic [SF_W-1:0] sf);
    logic [SF_W-1:0] f;
    f = sf;
    if (f < SF_MIN) f = SF_MIN;
    if (f > SF_MAX) f = SF_MAX;
    return f;
  endfunction

  function automatic logic [RCNT_W-1:0] eff_runs(input logic tier, input logic [SF_W-1:0] sf);
    logic [RCNT_W-1:0] r;
    if (!tier) begin
      r = RCNT_W'(1);
    end else begin
      r = RCNT_W'(eff_factor(sf));
      if (r > RCNT_W'(MAX_RUNS)) r = RCNT_W'(MAX_RUNS);
    end
    return r;
  endfunction

  function automatic logic [FILL_W-1:0] eff_epr(input logic [CFG_DATA_W-1:0] e);
    logic [FILL_W-1:0] r;
    if (e == '0) begin
      r = FILL_W'(1);
    end else if (32'(e) > 32'(MAX_RUN_ENTRIES)) begin
      r = FILL_W'(MAX_RUN_ENTRIES);
    end else begin
      r = FILL_W'(e);
    end
    return r;
  endfunction

endpackage

@@ src/lrt_store.sv @@
module lrt_store (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [lrt_pkg::ADDR_W-1:0] waddr_i,
  input  lrt_pkg::entry_t       wdata_i,
  input  logic                  re_i,
  input  logic [lrt_pkg::ADDR_W-1:0] raddr_i,
  output lrt_pkg::entry_t       rdata_o
);
  import lrt_pkg::*;

  entry_t mem_q [MAX_RUNS * MAX_RUN_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lrt_lim_div.sv @@
module lrt_lim_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lrt_pkg::FILL_W-1:0] epr_i,
  input  logic [lrt_pkg::SF_W-1:0]   factor_i,
  output logic                       busy_o,
  output logic [lrt_pkg::FILL_W-1:0] limit_o
);
  import lrt_pkg::*;

  localparam int STEP_W = $clog2(FILL_W + 1);

  // Restoring division of the run capacity by the size factor, one quotient
  // bit a cycle, then one multiply by (factor - 1).
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  mul_q, mul_d;
  logic [FILL_W-1:0]     dvd_q, dvd_d;
  logic [SF_W-1:0]       rem_q, rem_d;
  logic [FILL_W-1:0]     quo_q, quo_d;
  logic [FILL_W-1:0]     limit_q, limit_d;
  logic [SF_W-1:0]       rem_sh;
  logic                  ge;
  logic [SF_W-1:0]       fm1;
  logic [FILL_W+SF_W-1:0] prod;

  assign rem_sh = {rem_q[SF_W-2:0], dvd_q[FILL_W-1]};
  assign ge     = rem_sh >= factor_i;
  assign fm1    = factor_i - SF_W'(1);
  assign prod   = (FILL_W+SF_W)'(quo_q) * (FILL_W+SF_W)'(fm1);

  always_comb begin
    step_d  = step_q;
    mul_d   = mul_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    limit_d = limit_q;
    if (start_i) begin
      step_d = STEP_W'(FILL_W);
      mul_d  = 1'b0;
      dvd_d  = epr_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (step_q != '0) begin
      dvd_d  = {dvd_q[FILL_W-2:0], 1'b0};
      rem_d  = ge ? rem_sh - factor_i : rem_sh;
      quo_d  = {quo_q[FILL_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      mul_d  = (step_q == STEP_W'(1));
    end else if (mul_q) begin
      limit_d = prod[FILL_W-1:0];
      mul_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      mul_q   <= 1'b0;
      limit_q <= LIM_RESET;
    end else begin
      step_q  <= step_d;
      mul_q   <= mul_d;
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o  = (step_q != '0) || mul_q;
  assign limit_o = limit_q;

endmodule

@@ src/lsm_level_range_table.sv @@
// One level of an LSM tree: a table of (low key, high key, block) entries kept
// in runs in a single-port-read entry memory. Inserts, overlap queries and clears
// pass the EXEC and DONE states and then put their word on the output register;
// DONE waits while the output stalls or the limit is recomputed, and the next
// item is taken only once the block is back in IDLE. A point lookup visits every
// started run, up to the effective run count, and searches it by halving the
// window [lo, end) on key_low: the RUN state opens the window, and each probe of
// the entry memory passes a READ state (the registered read) and a CMP state
// (the compare). A lookup gives one hit word per run that covers the key, the
// final one flagged last, or a single miss word. The leveling full limit is
// recomputed by a small serial divider after each configuration write; words
// are held back until it has finished. The entry memory needs no clearing after
// reset: only written positions are read.
module lsm_level_range_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lrt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lrt_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lrt_pkg::out_word_t                out_word_o
);
  import lrt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration.
  logic                  tier_q;
  logic [SF_W-1:0]       sf_q;
  logic [CFG_DATA_W-1:0] epr_q;
  logic                  div_start_q;

  // Level state.
  logic [2:0]          state_q;
  logic [FILL_W-1:0]   run_fill_q [MAX_RUNS];
  logic [RCNT_W-1:0]   active_q;
  logic [RCNT_W-1:0]   started_q;
  logic [CNT_W-1:0]    total_q;
  logic [KEY_BITS-1:0] min_q;
  logic [KEY_BITS-1:0] max_q;

  // Work registers.
  in_word_t            in_q;
  logic [2:0]          res_status_q;
  logic [RCNT_W-1:0]   run_q;
  logic [FILL_W-1:0]   lo_q;
  logic [FILL_W-1:0]   end_q;
  logic                pend_v_q;
  logic [RUN_W-1:0]    pend_run_q;
  entry_t              pend_ent_q;

  out_word_t           out_q;
  logic                out_valid_q;

  // Derived values.
  logic [SF_W-1:0]     f_eff;
  logic [RCNT_W-1:0]   runs_eff;
  logic [FILL_W-1:0]   epr_eff;
  logic [RCNT_W-1:0]   lim_runs;
  logic [FILL_W-1:0]   full_lim;
  logic                lim_busy;
  logic                div_busy;
  logic                level_full;
  logic [RUN_W-1:0]    fill_idx;
  logic [FILL_W-1:0]   fill_rd;
  logic [FILL_W-1:0]   fill_inc;
  logic                ins_reject;
  logic                ovl;
  logic [FILL_W:0]     mid_sum;
  logic [POS_W-1:0]    mid;
  logic                probe;
  entry_t              rd_ent;
  entry_t              wr_ent;
  logic                wr_en;
  logic                hit;
  logic                out_free;
  logic                emit_ok;
  logic                emit_en;
  out_word_t           emit_w;
  logic                accept;

  assign f_eff    = eff_factor(sf_q);
  assign runs_eff = eff_runs(tier_q, sf_q);
  assign epr_eff  = eff_epr(epr_q);
  assign lim_runs = (started_q < runs_eff) ? started_q : runs_eff;
  assign lim_busy = div_start_q || div_busy;

  assign level_full = tier_q ? (active_q >= runs_eff)
                             : (total_q >= CNT_W'(full_lim));

  assign fill_idx   = (state_q == S_EXEC) ? active_q[RUN_W-1:0] : run_q[RUN_W-1:0];
  assign fill_rd    = run_fill_q[fill_idx];
  assign fill_inc   = fill_rd + FILL_W'(1);
  assign ins_reject = (active_q >= runs_eff) || (active_q >= RCNT_W'(MAX_RUNS)) ||
                      (fill_rd >= epr_eff);
  assign ovl        = !((min_q > in_q.key_high) || (max_q < in_q.key_low));

  // Midpoint of the half-open window [lo, end).
  assign mid_sum = {1'b0, lo_q} + {1'b0, end_q} - (FILL_W+1)'(1);
  assign mid     = mid_sum[POS_W:1];
  assign probe   = (state_q == S_READ) && (lo_q < end_q);

  assign hit = (rd_ent.key_low <= in_q.key_low) && (rd_ent.key_high >= in_q.key_low);

  assign wr_en = (state_q == S_EXEC) && (in_q.action == ACT_INSERT) && !ins_reject;
  assign wr_ent.key_low  = in_q.key_low;
  assign wr_ent.key_high = in_q.key_high;
  assign wr_ent.block    = in_q.block_address;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_ok  = out_free && !lim_busy;

  lrt_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({active_q[RUN_W-1:0], fill_rd[POS_W-1:0]}),
    .wdata_i (wr_ent),
    .re_i    (probe),
    .raddr_i ({run_q[RUN_W-1:0], mid}),
    .rdata_o (rd_ent)
  );

  lrt_lim_div u_lim_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start_q),
    .epr_i    (epr_eff),
    .factor_i (f_eff),
    .busy_o   (div_busy),
    .limit_o  (full_lim)
  );

  // Word for the output register; level state is already that after the item.
  always_comb begin
    emit_en            = 1'b0;
    emit_w             = '0;
    emit_w.level_full  = level_full;
    emit_w.entry_count = total_q;
    case (state_q)
      S_RUN: begin
        if ((run_q >= lim_runs) && pend_v_q) begin
          emit_en               = emit_ok;
          emit_w.status         = ST_HIT;
          emit_w.run_index      = 3'(pend_run_q);
          emit_w.found_key_low  = pend_ent_q.key_low;
          emit_w.found_key_high = pend_ent_q.key_high;
          emit_w.found_block    = pend_ent_q.block;
          emit_w.last           = 1'b1;
        end
      end
      S_PUSH: begin
        emit_en               = emit_ok;
        emit_w.status         = ST_HIT;
        emit_w.run_index      = 3'(pend_run_q);
        emit_w.found_key_low  = pend_ent_q.key_low;
        emit_w.found_key_high = pend_ent_q.key_high;
        emit_w.found_block    = pend_ent_q.block;
      end
      S_DONE: begin
        emit_en       = emit_ok;
        emit_w.status = res_status_q;
        emit_w.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tier_q      <= 1'b0;
      sf_q        <= SF_RESET;
      epr_q       <= EPR_RESET;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIERING:         tier_q <= cfg_wdata_i[0];
          CFG_SIZE_FACTOR:     sf_q   <= cfg_wdata_i[SF_W-1:0];
          CFG_ENTRIES_PER_RUN: epr_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      for (int i = 0; i < MAX_RUNS; i++) begin
        run_fill_q[i] <= '0;
      end
      active_q     <= '0;
      started_q    <= '0;
      total_q      <= '0;
      min_q        <= '1;
      max_q        <= '0;
      res_status_q <= ST_INSERTED;
      run_q        <= '0;
      lo_q         <= '0;
      end_q        <= '0;
      pend_v_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_DONE;
          case (in_q.action)
            ACT_INSERT: begin
              if (ins_reject) begin
                res_status_q <= ST_REJECTED;
              end else begin
                res_status_q <= ST_INSERTED;
                if (min_q > in_q.key_low)  min_q <= in_q.key_low;
                if (max_q < in_q.key_high) max_q <= in_q.key_high;
                run_fill_q[fill_idx] <= fill_inc;
                total_q <= total_q + CNT_W'(1);
                if (fill_rd == '0) started_q <= started_q + RCNT_W'(1);
                if (fill_inc >= epr_eff) active_q <= active_q + RCNT_W'(1);
              end
            end
            ACT_LOOKUP: begin
              if (total_q == '0) begin
                res_status_q <= ST_MISS;
              end else begin
                run_q    <= '0;
                pend_v_q <= 1'b0;
                state_q  <= S_RUN;
              end
            end
            ACT_OVERLAP: begin
              res_status_q <= ovl ? ST_OVERLAPS : ST_NO_OVERLAP;
            end
            ACT_CLEAR: begin
              res_status_q <= ST_CLEARED;
              for (int i = 0; i < MAX_RUNS; i++) begin
                run_fill_q[i] <= '0;
              end
              active_q  <= '0;
              started_q <= '0;
              total_q   <= '0;
              min_q     <= '1;
              max_q     <= '0;
            end
            default: begin
            end
          endcase
        end
        S_RUN: begin
          if (run_q >= lim_runs) begin
            // All runs searched: flush the held hit as the last word, or miss.
            if (pend_v_q) begin
              if (emit_en) state_q <= S_IDLE;
            end else begin
              res_status_q <= ST_MISS;
              state_q      <= S_DONE;
            end
          end else begin
            lo_q    <= '0;
            end_q   <= fill_rd;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (probe) begin
            state_q <= S_CMP;
          end else begin
            run_q   <= run_q + RCNT_W'(1);
            state_q <= S_RUN;
          end
        end
        S_CMP: begin
          if (hit) begin
            // A hit is held back one step so that the final one can carry last.
            if (pend_v_q) begin
              state_q <= S_PUSH;
            end else begin
              pend_v_q   <= 1'b1;
              pend_run_q <= run_q[RUN_W-1:0];
              run_q      <= run_q + RCNT_W'(1);
              state_q    <= S_RUN;
            end
          end else begin
            if (rd_ent.key_low > in_q.key_low) begin
              end_q <= FILL_W'(mid);
            end else begin
              lo_q <= FILL_W'(mid) + FILL_W'(1);
            end
            state_q <= S_READ;
          end
        end
        S_PUSH: begin
          if (emit_en) begin
            pend_run_q <= run_q[RUN_W-1:0];
            run_q      <= run_q + RCNT_W'(1);
            state_q    <= S_RUN;
          end
        end
        S_DONE: begin
          if (emit_en) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_word_i;
    if ((state_q == S_CMP && hit && !pend_v_q) || (state_q == S_PUSH && emit_en)) begin
      pend_ent_q <= rd_ent;
    end
    if (emit_en) out_q <= emit_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_active_started : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= started_q)
    else $error("active run lies beyond the started runs");

  a_push_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> pend_v_q)
    else $error("hit push without a held hit");

  a_probe_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe |-> ({1'b0, mid} < run_fill_q[run_q[RUN_W-1:0]]))
    else $error("probe beyond the fill of the run");

  a_cmp_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> $past(probe))
    else $error("compare without a memory read");
`endif

endmodule
